[src/iee_pkg.sv]
//------------------------------------------------------------------------------
// Infix expression evaluator package
// Shared types and codes for the controller and the datapath.
//------------------------------------------------------------------------------
`default_nettype none
package iee_pkg;

  localparam logic [7:0] ChMul = 8'h2A;
  localparam logic [7:0] ChDiv = 8'h2F;
  localparam logic [7:0] ChAdd = 8'h2B;
  localparam logic [7:0] ChSub = 8'h2D;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChCr = 8'h0D;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StSyntax = 2'd1;
  localparam logic [1:0] StDivZero = 2'd2;

  typedef enum logic [1:0] {
    PhStart = 2'd0,
    PhSign = 2'd1,
    PhDigits = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] result_value;
    logic [1:0]         status;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic add_digit;
    logic set_neg;
    logic neg_value;
    logic fold_mul;
    logic div_start;
    logic fold_term;
    logic sub_value;
    logic set_div;
    logic div_value;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic num_zero;
    logic div_busy;
    logic div_done;
    logic pend_div;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/iee_datapath.sv]
//------------------------------------------------------------------------------
// Infix expression evaluator datapath
// Number accumulation, term and sum registers, and a shared iterative unit
// that multiplies 16 bits per cycle or divides one bit per cycle.
//------------------------------------------------------------------------------
`default_nettype none
module iee_datapath #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  iee_pkg::dp_cmd_t      cmd_i,
  input  wire  [3:0]            digit_i,
  output iee_pkg::dp_stat_t     stat_o,
  output logic [VALUE_BITS-1:0] sum_o
);
  localparam int unsigned CW = $clog2(VALUE_BITS + 1);
  localparam int unsigned MulSteps = (VALUE_BITS + 15) / 16;
  localparam logic [VALUE_BITS-1:0] VSign = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] One = {{(VALUE_BITS-1){1'b0}}, 1'b1};

  logic [VALUE_BITS-1:0] sum_q, sum_d, term_q, term_d, mag_q, mag_d;
  logic                  neg_q, neg_d, pdiv_q, pdiv_d;
  logic [VALUE_BITS-1:0] num_v, tmag, nmag, mag10;
  logic [VALUE_BITS-1:0] dq_q, dq_d, dd_q, dd_d, rem_q, rem_d;
  logic                  dneg_q, dneg_d, mul_q, mul_d;
  logic                  busy_q, busy_d, done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [VALUE_BITS:0]   rsh, rdif;
  logic [VALUE_BITS+3:0] mag10w, limit;
  logic [VALUE_BITS+15:0] pp;

  always_comb begin
    if (neg_q) begin
      num_v = (mag_q >= VSign) ? VSign : (~mag_q + One);
    end else begin
      num_v = (mag_q >= VSign) ? (VSign - One) : mag_q;
    end
    tmag = term_q[VALUE_BITS-1] ? (~term_q + One) : term_q;
    nmag = num_v[VALUE_BITS-1] ? (~num_v + One) : num_v;
    mag10w = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} +
             {{VALUE_BITS{1'b0}}, digit_i};
    limit = {4'd0, VSign};
    mag10 = (mag10w > limit) ? VSign : mag10w[VALUE_BITS-1:0];
    rsh = {rem_q, dq_q[VALUE_BITS-1]};
    rdif = rsh - {1'b0, dd_q};
    pp = dd_q * dq_q[15:0];

    sum_d = sum_q;
    term_d = term_q;
    mag_d = mag_q;
    neg_d = neg_q;
    pdiv_d = pdiv_q;
    dq_d = dq_q;
    dd_d = dd_q;
    rem_d = rem_q;
    dneg_d = dneg_q;
    mul_d = mul_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;

    if (cmd_i.clear) begin
      sum_d = '0;
      term_d = One;
      mag_d = '0;
      neg_d = 1'b0;
      pdiv_d = 1'b0;
    end
    if (cmd_i.add_digit) begin
      mag_d = mag10;
    end
    if (cmd_i.set_neg) begin
      neg_d = cmd_i.neg_value;
    end
    if (cmd_i.fold_mul) begin
      dq_d = num_v;
      dd_d = term_q;
      rem_d = '0;
      mul_d = 1'b1;
      cnt_d = CW'(MulSteps);
      busy_d = 1'b1;
      mag_d = '0;
      neg_d = 1'b0;
    end
    if (cmd_i.div_start) begin
      dq_d = tmag;
      dd_d = nmag;
      rem_d = '0;
      dneg_d = term_q[VALUE_BITS-1] ^ num_v[VALUE_BITS-1];
      mul_d = 1'b0;
      cnt_d = CW'(VALUE_BITS);
      busy_d = 1'b1;
      mag_d = '0;
      neg_d = 1'b0;
    end
    if (busy_q) begin
      if (mul_q) begin
        rem_d = rem_q + pp[VALUE_BITS-1:0];
        dd_d = dd_q << 16;
        dq_d = dq_q >> 16;
      end else if (!rdif[VALUE_BITS]) begin
        rem_d = rdif[VALUE_BITS-1:0];
        dq_d = {dq_q[VALUE_BITS-2:0], 1'b1};
      end else begin
        rem_d = rsh[VALUE_BITS-1:0];
        dq_d = {dq_q[VALUE_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (done_q) begin
      term_d = mul_q ? rem_q : (dneg_q ? (~dq_q + One) : dq_q);
    end
    if (cmd_i.fold_term) begin
      sum_d = cmd_i.sub_value ? (sum_q - term_q) : (sum_q + term_q);
      term_d = One;
    end
    if (cmd_i.set_div) begin
      pdiv_d = cmd_i.div_value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      term_q <= One;
      mag_q <= '0;
      neg_q <= 1'b0;
      pdiv_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
      dq_q <= '0;
      dd_q <= '0;
      rem_q <= '0;
      dneg_q <= 1'b0;
      mul_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      term_q <= term_d;
      mag_q <= mag_d;
      neg_q <= neg_d;
      pdiv_q <= pdiv_d;
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
      dq_q <= dq_d;
      dd_q <= dd_d;
      rem_q <= rem_d;
      dneg_q <= dneg_d;
      mul_q <= mul_d;
    end
  end

  assign stat_o.num_zero = (num_v == '0);
  assign stat_o.div_busy = busy_q;
  assign stat_o.div_done = done_q;
  assign stat_o.pend_div = pdiv_q;
  assign sum_o = sum_q;
endmodule
`default_nettype wire

[src/iee_ctrl.sv]
//------------------------------------------------------------------------------
// Infix expression evaluator controller
// Parses characters, sequences folds and the divider, and issues results.
//------------------------------------------------------------------------------
`default_nettype none
module iee_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  iee_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [1:0]          out_status_o,
  output logic                out_take_sum_o,
  output iee_pkg::dp_cmd_t    cmd_o,
  input  iee_pkg::dp_stat_t   stat_i
);
  typedef enum logic [1:0] {
    SIdle = 2'd0,
    SBusy = 2'd1,
    SSum = 2'd2,
    SOut = 2'd3
  } state_e;

  state_e         state_q, state_d;
  iee_pkg::phase_e ph_q, ph_d;
  logic [1:0]     err_q, err_d;
  logic           sub_q, sub_d, pmul_q, pmul_d, pend_q, pend_d;
  logic           nsub_q, nsub_d;
  logic           pdivv_q, pdivv_d;
  logic           ov_q, ov_d;
  logic [1:0]     ost_q, ost_d;
  logic           take_q, take_d;
  logic           acc, is_dig, is_sign, is_mul, is_blank;
  logic [7:0]     c;

  assign in_stall_o = (state_q != SIdle) || (ov_q && out_stall_i);
  assign acc = in_valid_i && !in_stall_o;
  assign c = in_data_i.character;
  assign is_dig = (c >= iee_pkg::ChZero) && (c <= iee_pkg::ChNine);
  assign is_sign = (c == iee_pkg::ChAdd) || (c == iee_pkg::ChSub);
  assign is_mul = (c == iee_pkg::ChMul) || (c == iee_pkg::ChDiv);
  assign is_blank = (c == iee_pkg::ChSpace) ||
                    ((c >= iee_pkg::ChTab) && (c <= iee_pkg::ChCr));

  always_comb begin
    state_d = state_q;
    ph_d = ph_q;
    err_d = err_q;
    sub_d = sub_q;
    nsub_d = nsub_q;
    pmul_d = pmul_q;
    pend_d = pend_q;
    pdivv_d = pdivv_q;
    ov_d = ov_q && out_stall_i;
    ost_d = ost_q;
    take_d = take_q;
    cmd_o = '0;
    case (state_q)
      SIdle: begin
        if (acc && in_data_i.end_of_text) begin
          if (err_q != iee_pkg::StOk || ph_q != iee_pkg::PhDigits) begin
            if (err_q == iee_pkg::StOk) err_d = iee_pkg::StSyntax;
            state_d = SOut;
          end else if (stat_i.pend_div) begin
            if (stat_i.num_zero) begin
              err_d = iee_pkg::StDivZero;
              state_d = SOut;
            end else begin
              cmd_o.div_start = 1'b1;
              pend_d = 1'b1;
              state_d = SBusy;
            end
          end else begin
            cmd_o.fold_mul = 1'b1;
            pend_d = 1'b1;
            state_d = SBusy;
          end
        end else if (acc && err_q == iee_pkg::StOk) begin
          if (is_dig) begin
            cmd_o.add_digit = 1'b1;
            ph_d = iee_pkg::PhDigits;
          end else if (ph_q == iee_pkg::PhStart) begin
            if (is_sign) begin
              cmd_o.set_neg = 1'b1;
              cmd_o.neg_value = (c == iee_pkg::ChSub);
              ph_d = iee_pkg::PhSign;
            end else if (!is_blank) begin
              err_d = iee_pkg::StSyntax;
            end
          end else if (ph_q == iee_pkg::PhDigits && (is_sign || is_mul)) begin
            if (stat_i.pend_div && stat_i.num_zero) begin
              err_d = iee_pkg::StDivZero;
            end else begin
              ph_d = iee_pkg::PhStart;
              pend_d = 1'b0;
              pmul_d = is_mul;
              pdivv_d = (c == iee_pkg::ChDiv);
              nsub_d = (c == iee_pkg::ChSub);
              if (stat_i.pend_div) begin
                cmd_o.div_start = 1'b1;
              end else begin
                cmd_o.fold_mul = 1'b1;
              end
              state_d = SBusy;
            end
          end else begin
            err_d = iee_pkg::StSyntax;
          end
        end
      end
      SBusy: begin
        if (stat_i.div_done) state_d = SSum;
      end
      SSum: begin
        if (pend_q) begin
          cmd_o.fold_term = 1'b1;
          cmd_o.sub_value = sub_q;
          state_d = SOut;
        end else if (pmul_q) begin
          cmd_o.set_div = 1'b1;
          cmd_o.div_value = pdivv_q;
          state_d = SIdle;
        end else begin
          cmd_o.fold_term = 1'b1;
          cmd_o.sub_value = sub_q;
          cmd_o.set_div = 1'b1;
          sub_d = nsub_q;
          state_d = SIdle;
        end
      end
      SOut: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          ost_d = err_q;
          take_d = (err_q == iee_pkg::StOk);
          cmd_o.clear = 1'b1;
          err_d = iee_pkg::StOk;
          ph_d = iee_pkg::PhStart;
          sub_d = 1'b0;
          nsub_d = 1'b0;
          pmul_d = 1'b0;
          pend_d = 1'b0;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      ph_q <= iee_pkg::PhStart;
      err_q <= iee_pkg::StOk;
      sub_q <= 1'b0;
      nsub_q <= 1'b0;
      pmul_q <= 1'b0;
      pend_q <= 1'b0;
      pdivv_q <= 1'b0;
      ov_q <= 1'b0;
      ost_q <= iee_pkg::StOk;
      take_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q <= ph_d;
      err_q <= err_d;
      sub_q <= sub_d;
      nsub_q <= nsub_d;
      pmul_q <= pmul_d;
      pend_q <= pend_d;
      pdivv_q <= pdivv_d;
      ov_q <= ov_d;
      ost_q <= ost_d;
      take_q <= take_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_status_o = ost_q;
  assign out_take_sum_o = take_q;
endmodule
`default_nettype wire

[src/infix_expression_evaluator_top.sv]
// A digit, sign or blank is taken while the controller is idle. An operator after a number
// folds it into the term through the shared unit, as a product, or as a quotient by the
// one-bit-per-cycle divider after a divisor. An end marker shows its result with no fold
// on an error, else after the same fold, and the next transaction is taken once the result
// is issued. One item is in work at a time.
// Reset is asynchronous and active low and returns the parser to the start.
//------------------------------------------------------------------------------
// Infix expression evaluator
// Evaluates a streamed integer expression with two precedence levels.
//------------------------------------------------------------------------------
`default_nettype none
module infix_expression_evaluator_top #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  iee_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output iee_pkg::out_item_t  out_data_o
);
  iee_pkg::dp_cmd_t      cmd;
  iee_pkg::dp_stat_t     stat;
  logic [VALUE_BITS-1:0] sum;
  logic [VALUE_BITS-1:0] res_q;
  logic [1:0]            ost;
  logic                  take;

  iee_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .out_status_o(ost), .out_take_sum_o(take),
    .cmd_o(cmd), .stat_i(stat)
  );

  iee_datapath #(.VALUE_BITS(VALUE_BITS)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd),
    .digit_i(in_data_i.character[3:0]), .stat_o(stat), .sum_o(sum)
  );

  always_ff @(posedge clk_i) begin
    if (cmd.clear) res_q <= sum;
  end

  assign out_data_o.result_value = take ? 64'($signed(res_q)) : 64'sd0;
  assign out_data_o.status = ost;

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == iee_pkg::StOk ||
                     out_data_o.status == iee_pkg::StSyntax ||
                     out_data_o.status == iee_pkg::StDivZero))
    else $error("bad status");
  a_div_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_busy |-> in_stall_o)
    else $error("input taken during division");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != iee_pkg::StOk) |->
      (out_data_o.result_value == 64'sd0))
    else $error("nonzero value with error");
`endif
endmodule
`default_nettype wire

[tb/sv/infix_expression_evaluator_top_tb.sv]
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Infix expression evaluator testbench
// Streams characters of integer expressions into the evaluator, predicts each
// result with a behavioral calculator, and compares every result transaction
// against the oldest predicted value and status.
//------------------------------------------------------------------------------
module infix_expression_evaluator_top_tb;

  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;
  localparam int unsigned IdleLimit = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  iee_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  iee_pkg::out_item_t out_data;

  infix_expression_evaluator_top #(.VALUE_BITS(64)) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  // Calculator state.
  logic [63:0] calc_sum;
  logic [63:0] calc_term;
  logic [63:0] calc_mag;
  logic calc_neg;
  logic calc_sub;
  logic calc_div;
  iee_pkg::phase_e calc_phase;
  logic [1:0] calc_err;

  iee_pkg::out_item_t expected_results[$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  logic hold_off;
  logic timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic calc_clear();
    calc_sum = '0;
    calc_term = 64'd1;
    calc_mag = '0;
    calc_neg = 1'b0;
    calc_sub = 1'b0;
    calc_div = 1'b0;
    calc_phase = iee_pkg::PhStart;
    calc_err = iee_pkg::StOk;
  endtask

  function automatic logic [63:0] abs_of(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  task automatic calc_fold_number();
    logic [63:0] v;
    logic [63:0] q;
    if (calc_neg) v = (calc_mag >= SignBit) ? SignBit : -calc_mag;
    else v = (calc_mag >= SignBit) ? SignBit - 64'd1 : calc_mag;
    if (calc_div) begin
      if (v == 0) begin
        if (calc_err == iee_pkg::StOk) calc_err = iee_pkg::StDivZero;
        return;
      end
      q = abs_of(calc_term) / abs_of(v);
      calc_term = (calc_term[63] ^ v[63]) ? -q : q;
    end else begin
      calc_term = calc_term * v;
    end
    calc_mag = '0;
    calc_neg = 1'b0;
  endtask

  task automatic calc_fold_term();
    calc_sum = calc_sub ? calc_sum - calc_term : calc_sum + calc_term;
    calc_term = 64'd1;
  endtask

  task automatic calc_take(logic [7:0] c);
    logic is_digit;
    logic is_sign;
    logic is_mul;
    logic [63:0] d;
    is_digit = c >= iee_pkg::ChZero && c <= iee_pkg::ChNine;
    is_sign = c == iee_pkg::ChAdd || c == iee_pkg::ChSub;
    is_mul = c == iee_pkg::ChMul || c == iee_pkg::ChDiv;
    if (is_digit) begin
      d = 64'(c - iee_pkg::ChZero);
      if (calc_mag > (SignBit - d) / 10) calc_mag = SignBit;
      else calc_mag = calc_mag * 10 + d;
      calc_phase = iee_pkg::PhDigits;
    end else if (calc_phase == iee_pkg::PhStart) begin
      if (c == iee_pkg::ChSpace || (c >= iee_pkg::ChTab && c <= iee_pkg::ChCr)) begin
      end else if (is_sign) begin
        calc_neg = c == iee_pkg::ChSub;
        calc_phase = iee_pkg::PhSign;
      end else if (calc_err == iee_pkg::StOk) begin
        calc_err = iee_pkg::StSyntax;
      end
    end else if (calc_phase == iee_pkg::PhDigits && (is_sign || is_mul)) begin
      calc_fold_number();
      if (calc_err == iee_pkg::StOk) begin
        if (is_mul) begin
          calc_div = c == iee_pkg::ChDiv;
        end else begin
          calc_fold_term();
          calc_sub = c == iee_pkg::ChSub;
          calc_div = 1'b0;
        end
        calc_phase = iee_pkg::PhStart;
      end
    end else if (calc_err == iee_pkg::StOk) begin
      calc_err = iee_pkg::StSyntax;
    end
  endtask

  task automatic calc_step(iee_pkg::in_item_t item);
    iee_pkg::out_item_t r;
    if (!item.end_of_text) begin
      if (calc_err == iee_pkg::StOk) calc_take(item.character);
    end else begin
      if (calc_err == iee_pkg::StOk) begin
        if (calc_phase != iee_pkg::PhDigits) begin
          calc_err = iee_pkg::StSyntax;
        end else begin
          calc_fold_number();
          if (calc_err == iee_pkg::StOk) calc_fold_term();
        end
      end
      r.result_value = (calc_err == iee_pkg::StOk) ? calc_sum : '0;
      r.status = calc_err;
      expected_results.push_back(r);
      calc_clear();
    end
  endtask

  task automatic random_gap();
    int unsigned n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_item(logic [7:0] c, logic eot);
    in_data.character = c;
    in_data.end_of_text = eot;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    calc_step(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_text(string s, bit gaps);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], 1'b0);
      if (gaps) random_gap();
    end
    send_item(8'($urandom_range(1, 255)), 1'b1);
    if (gaps) random_gap();
  endtask

  function automatic string with_char(string s, logic [7:0] ch);
    string t;
    t = {s, " "};
    t[t.len() - 1] = ch;
    return t;
  endfunction

  function automatic string random_number();
    string s;
    int unsigned n;
    s = "";
    if ($urandom_range(0, 3) == 0) s = {s, " "};
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 1) != 0) s = {s, "-"};
      else s = {s, "+"};
    end
    case ($urandom_range(0, 9))
      0: s = {s, "9223372036854775808"};
      1: s = {s, "99999999999999999999"};
      2: s = {s, "0"};
      default: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = with_char(s, 8'($urandom_range(48, 57)));
      end
    endcase
    return s;
  endfunction

  function automatic string random_expression();
    string s;
    string ops;
    int unsigned n;
    ops = "+-*/";
    n = $urandom_range(0, 4);
    s = random_number();
    for (int i = 0; i < n; i++) begin
      s = with_char(s, ops[$urandom_range(0, 3)]);
      s = {s, random_number()};
    end
    return s;
  endfunction

  task automatic test_directed();
    send_text("1+2*3-4/2", 1'b0);
    send_text("9223372036854775807", 1'b0);
    send_text("-9223372036854775808", 1'b0);
    send_text("99999999999999999999", 1'b0);
    send_text("-9223372036854775808/-1", 1'b0);
    send_text("7/0", 1'b0);
    send_text("\t\n\v\f\r 5", 1'b0);
    send_text("- 5", 1'b0);
    send_text("5 ", 1'b0);
    send_text("5+", 1'b0);
    send_text("", 1'b0);
    send_text("*3", 1'b0);
    send_text("3&4", 1'b0);
    send_text("3/0+x", 1'b0);
    send_text("-7/2", 1'b0);
    send_text("1-2*3", 1'b0);
    send_text("4294967296*4294967296", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random();
    string s;
    int unsigned sent;
    sent = 0;
    while (sent < 880) begin
      s = random_expression();
      if ($urandom_range(0, 9) == 0) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
      send_text(s, 1'b1);
      sent += s.len() + 1;
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_text("12*3-8/3", 1'b0);
  endtask

  // Result checker.
  always @(posedge clk) begin
    iee_pkg::out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %0d status %0d",
          out_data.result_value, out_data.status);
      end else begin
        exp_item = expected_results.pop_front();
        if (exp_item.result_value !== out_data.result_value ||
            exp_item.status !== out_data.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("expected %0d/%0d, got %0d/%0d",
            exp_item.result_value, exp_item.status, out_data.result_value, out_data.status);
        end
      end
    end
  end

  // Receiver stalls, with one long hold-off on request.
  initial begin
    int unsigned n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
        out_stall = 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  initial begin
    timed_out = 1'b0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        timed_out = 1'b1;
        $display("infix_expression_evaluator_top: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    hold_off = 1'b0;
    mismatch_count = 0;
    calc_clear();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_backpressure();
    test_random();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("infix_expression_evaluator_top: match");
    end else begin
      $display("infix_expression_evaluator_top: mismatch");
    end
    $finish;
  end
endmodule
